// ----- hdl/hte_pkg.sv -----
// Shared types and constants for the Huffman table encoder.
// Depends on nothing; used by hdl/huffman_table_encoder.sv.
package hte_pkg;

  // Longest code the table keeps; loads above the cap saturate.
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_CAP      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

  // Table depth and the most results one request can give
  localparam int TBL_DEPTH    = 256;
  localparam int MAX_RESULTS  = 4;

  // Request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_len;
    logic        entry_present;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [31:0] bit_count;
    logic        error_seen;
    logic        last;
  } res_t;

endpackage

// ----- hdl/huffman_table_encoder.sv -----
// Huffman table encoder top level: code table memory, bit packer, result group.
// Depends on hdl/hte_pkg.sv.
//
//  channel | direction | handshake           | beat payload
//  --------+-----------+---------------------+----------------------------------
//  req     | in        | req_valid/req_stall | hte_pkg::req_t (load/encode/flush)
//  res     | out       | res_valid/res_stall | hte_pkg::res_t (byte/end/error)
//
// One request is taken per cycle while req_stall is low; its table read is registered
// at accept into the lookup stage, where it is packed. A request gives up to four result
// beats and the result port moves one beat per cycle while res_stall is low, so a request
// with results holds a later request that gives results until the last beat of its group
// is taken. Loads, zero-length codes and dropped encodes give no beat and never wait on
// the result port. Reset clears the present marks, the packer and the error flag;
// code and length entries hold garbage until loaded.
module huffman_table_encoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  hte_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output hte_pkg::res_t res
);

  localparam int NRES = hte_pkg::MAX_RESULTS;

  // Table memory: {length, code} per symbol
  logic [37:0] tbl [hte_pkg::TBL_DEPTH];
  logic [hte_pkg::TBL_DEPTH-1:0] present;

  // Lookup stage
  logic        a_valid;
  logic [1:0]  a_type;
  logic        a_present;
  logic [37:0] a_word;
  logic        a_adv;

  // Packer state
  logic [6:0]  pend_bits, pend_bits_next;
  logic [2:0]  pend_cnt, pend_cnt_next;
  logic [31:0] total_bits, total_bits_next;
  logic        err_flag, err_flag_next;

  // Result group
  hte_pkg::res_t grp [NRES];
  hte_pkg::res_t grp_next [NRES];
  logic [2:0]    grp_cnt, grp_cnt_next;
  logic          grp_free;

  // Per-request results
  hte_pkg::res_t r_new [NRES];
  logic [2:0]    r_n;

  logic        req_acc, res_acc;
  logic [5:0]  len_sat;

  // Packer datapath
  logic [5:0]  e_len;
  logic [31:0] e_code;
  logic [32:0] e_mask;
  logic [38:0] e_acc;
  logic [5:0]  e_cnt;
  logic [39:0] e_aligned;
  logic [7:0]  f_byte;

  assign req_acc = req_valid && !req_stall;
  assign res_acc = res_valid && !res_stall;

  // Saturate loaded length to the cap
  assign len_sat = (req.code_len > 6'(hte_pkg::LEN_CAP)) ? 6'(hte_pkg::LEN_CAP)
                                                          : req.code_len;

  // Table write on a load that marks the entry present, registered read on every accept
  always_ff @(posedge clk) begin
    if (req_acc && req.req_type == hte_pkg::REQ_LOAD && req.entry_present) begin
      tbl[req.symbol] <= {len_sat, req.code_bits};
    end
    if (req_acc) begin
      a_word <= tbl[req.symbol];
    end
  end

  // Present marks
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (req_acc && req.req_type == hte_pkg::REQ_LOAD) begin
      present[req.symbol] <= req.entry_present;
    end
  end

  // Lookup stage control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      a_type    <= req.req_type;
      a_present <= present[req.symbol];
    end
  end

  // Append code bits behind pending bits, then left-align for byte picking
  always_comb begin
    e_len     = a_word[37:32];
    e_mask    = (33'd1 << e_len) - 33'd1;
    e_code    = a_word[31:0] & e_mask[31:0];
    e_acc     = (39'(pend_bits) << e_len) | 39'(e_code);
    e_cnt     = 6'(pend_cnt) + e_len;
    e_aligned = 40'(e_acc) << (6'd40 - e_cnt);
    f_byte    = 8'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt}));
  end

  // Build the results and next packer state of the request in the lookup stage
  always_comb begin
    pend_bits_next  = pend_bits;
    pend_cnt_next   = pend_cnt;
    total_bits_next = total_bits;
    err_flag_next   = err_flag;
    r_n             = 3'd0;
    for (int k = 0; k < NRES; k++) begin
      r_new[k] = '0;
    end
    unique case (a_type)
      hte_pkg::REQ_ENCODE: begin
        if (!err_flag) begin
          if (!a_present) begin
            err_flag_next           = 1'b1;
            r_n                     = 3'd1;
            r_new[0].result_kind    = hte_pkg::KIND_MISSING;
            r_new[0].error_seen     = 1'b1;
            r_new[0].last           = 1'b1;
          end else begin
            r_n = e_cnt[5:3];
            for (int k = 0; k < NRES; k++) begin
              r_new[k].result_kind = hte_pkg::KIND_DATA;
              r_new[k].out_byte    = e_aligned[39-8*k -: 8];
              r_new[k].last        = (3'(k + 1) == e_cnt[5:3]);
            end
            pend_cnt_next   = e_cnt[2:0];
            pend_bits_next  = e_acc[6:0] & 7'((8'd1 << e_cnt[2:0]) - 8'd1);
            total_bits_next = total_bits + 32'(e_len);
          end
        end
      end
      hte_pkg::REQ_FLUSH: begin
        if (pend_cnt != 3'd0) begin
          r_n                  = 3'd2;
          r_new[0].result_kind = hte_pkg::KIND_DATA;
          r_new[0].out_byte    = f_byte;
          r_new[0].error_seen  = err_flag;
          r_new[1].result_kind = hte_pkg::KIND_END;
          r_new[1].bit_count   = total_bits;
          r_new[1].error_seen  = err_flag;
          r_new[1].last        = 1'b1;
        end else begin
          r_n                  = 3'd1;
          r_new[0].result_kind = hte_pkg::KIND_END;
          r_new[0].bit_count   = total_bits;
          r_new[0].error_seen  = err_flag;
          r_new[0].last        = 1'b1;
        end
        pend_bits_next  = '0;
        pend_cnt_next   = '0;
        total_bits_next = '0;
        err_flag_next   = 1'b0;
      end
      default: begin
        // load and unknown requests leave the packer alone
      end
    endcase
  end

  // Advance when the request gives nothing or the group can take its beats
  assign grp_free  = (grp_cnt == 3'd0) || (grp_cnt == 3'd1 && !res_stall);
  assign a_adv     = a_valid && (r_n == 3'd0 || grp_free);
  assign req_stall = a_valid && !a_adv;

  // Packer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_cnt   <= '0;
      total_bits <= '0;
      err_flag   <= 1'b0;
    end else if (a_adv) begin
      pend_bits  <= pend_bits_next;
      pend_cnt   <= pend_cnt_next;
      total_bits <= total_bits_next;
      err_flag   <= err_flag_next;
    end
  end

  // Result group: load a new request's beats or shift out one beat
  always_comb begin
    grp_cnt_next = grp_cnt;
    for (int k = 0; k < NRES; k++) begin
      grp_next[k] = grp[k];
    end
    if (a_adv && r_n != 3'd0) begin
      grp_cnt_next = r_n;
      for (int k = 0; k < NRES; k++) begin
        grp_next[k] = r_new[k];
      end
    end else if (res_acc) begin
      grp_cnt_next = grp_cnt - 3'd1;
      for (int k = 0; k < NRES - 1; k++) begin
        grp_next[k] = grp[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_cnt <= '0;
    end else begin
      grp_cnt <= grp_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NRES; k++) begin
      grp[k] <= grp_next[k];
    end
  end

  assign res_valid = (grp_cnt != 3'd0);
  assign res       = grp[0];

  // Group never holds more beats than one request can give
  a_grp_bound: assert property (@(posedge clk) disable iff (rst)
    grp_cnt <= 3'(NRES))
    else $error("result group count out of range");

  // A held lookup stage keeps its request; the table word may be unknown
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_adv |=> a_valid && $stable(a_type) && (a_word === $past(a_word)))
    else $error("lookup stage lost a held request");

  // A missing symbol raises the sticky error
  a_missing_err: assert property (@(posedge clk) disable iff (rst)
    a_adv && a_type == hte_pkg::REQ_ENCODE && !err_flag && !a_present |=> err_flag)
    else $error("missing symbol did not set the error flag");

  // The end-of-stream beat closes its request
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind == hte_pkg::KIND_END |-> res.last && grp_cnt == 3'd1)
    else $error("end beat is not the final beat");

endmodule

// ----- bench/hte_code_checker.sv -----
`timescale 1ns / 1ps
// Result checker for huffman_table_encoder: keeps its own code table and bit packer.
// Watches the request and result channels; depends on hdl/hte_pkg.sv.
module hte_code_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  hte_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_stall,
  input  hte_pkg::res_t res,
  output int            errors,
  output int            outstanding
);

  // Mirror of the code table and packer state
  logic [31:0]   code_tab [hte_pkg::TBL_DEPTH];
  logic [5:0]    len_tab  [hte_pkg::TBL_DEPTH];
  bit            live_tab [hte_pkg::TBL_DEPTH];
  logic [6:0]    held_bits;
  logic [2:0]    held_cnt;
  logic [31:0]   stream_bits;
  logic          miss_flag;
  hte_pkg::res_t owed_results[$];
  int            mismatches;

  function automatic hte_pkg::res_t make_beat(logic [1:0] kind, logic [7:0] byte_val,
                                              logic [31:0] count, logic err,
                                              logic last_flag);
    hte_pkg::res_t b;
    b.result_kind = kind;
    b.out_byte    = byte_val;
    b.bit_count   = count;
    b.error_seen  = err;
    b.last        = last_flag;
    return b;
  endfunction

  // Queue one owed beat at the tail
  task automatic owe_beat(input hte_pkg::res_t b);
    owed_results.insert(owed_results.size(), b);
  endtask

  // Work out the result beats that one accepted request owes
  task automatic pack_request(input hte_pkg::req_t r);
    logic [63:0] acc;
    int          len;
    int          cnt;
    int          nbytes;
    unique case (r.req_type)
      hte_pkg::REQ_LOAD: begin
        if (r.entry_present) begin
          code_tab[r.symbol] = r.code_bits;
          len_tab[r.symbol]  = (r.code_len > hte_pkg::LEN_CAP) ? 6'(hte_pkg::LEN_CAP)
                                                                 : r.code_len;
        end
        live_tab[r.symbol] = r.entry_present;
      end
      hte_pkg::REQ_ENCODE: begin
        // drop every encode while the sticky error stands
        if (!miss_flag) begin
          if (!live_tab[r.symbol]) begin
            miss_flag = 1'b1;
            owe_beat(make_beat(hte_pkg::KIND_MISSING, 8'h00, 32'h0, 1'b1, 1'b1));
          end else begin
            len = int'(len_tab[r.symbol]);
            acc = ({57'b0, held_bits} << len) |
                  ({32'b0, code_tab[r.symbol]} & ((64'd1 << len) - 64'd1));
            cnt = held_cnt + len;
            nbytes = cnt / 8;
            for (int i = 0; i < nbytes; i++) begin
              cnt -= 8;
              owe_beat(make_beat(hte_pkg::KIND_DATA, 8'(acc >> cnt), 32'h0,
                                 miss_flag, i == nbytes - 1));
            end
            held_cnt    = cnt[2:0];
            held_bits   = 7'(acc & ((64'd1 << cnt) - 64'd1));
            stream_bits = stream_bits + 32'(len);
          end
        end
      end
      hte_pkg::REQ_FLUSH: begin
        // pad the partial byte with zeros, then close the stream
        if (held_cnt != 3'd0)
          owe_beat(make_beat(hte_pkg::KIND_DATA,
                             8'({1'b0, held_bits} << (8 - held_cnt)),
                             32'h0, miss_flag, 1'b0));
        owe_beat(make_beat(hte_pkg::KIND_END, 8'h00, stream_bits, miss_flag, 1'b1));
        held_bits   = '0;
        held_cnt    = '0;
        stream_bits = '0;
        miss_flag   = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic string beat_text(hte_pkg::res_t b);
    return $sformatf("kind=%0d byte=%02h count=%0d err=%0b last=%0b",
                     b.result_kind, b.out_byte, b.bit_count, b.error_seen, b.last);
  endfunction

  task automatic report_beat(input string what, input hte_pkg::res_t want,
                             input hte_pkg::res_t got);
    mismatches++;
    $display("%0t %s: expected %s, got %s", $time, what, beat_text(want),
             beat_text(got));
  endtask

  // Compare each result beat with the oldest owed one, then predict the request beat
  always @(posedge clk) begin
    hte_pkg::res_t want;
    if (rst) begin
      owed_results.delete();
      foreach (live_tab[i]) live_tab[i] = 1'b0;
      held_bits   = '0;
      held_cnt    = '0;
      stream_bits = '0;
      miss_flag   = 1'b0;
      mismatches  = 0;
      errors      <= 0;
      outstanding <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (owed_results.size() == 0) begin
          report_beat("result beat with none owed", '0, res);
        end else begin
          want = owed_results.pop_front();
          if (res.result_kind !== want.result_kind || res.out_byte !== want.out_byte ||
              res.bit_count !== want.bit_count || res.error_seen !== want.error_seen ||
              res.last !== want.last)
            report_beat("result beat mismatch", want, res);
        end
      end
      if (req_valid && !req_stall)
        pack_request(req);
      errors      <= mismatches;
      outstanding <= owed_results.size();
    end
  end

endmodule

// ----- bench/huffman_table_encoder_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for huffman_table_encoder: clock, reset, request stimulus, result stalls.
// Depends on hdl/hte_pkg.sv, hdl/huffman_table_encoder.sv and bench/hte_code_checker.sv.
module huffman_table_encoder_tb;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 120;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  hte_pkg::req_t req       = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  hte_pkg::res_t res;
  int            errors;
  int            outstanding;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_tog       = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;
  int   cycle_cnt      = 0;
  int   sent           = 0;
  bit   tb_live [hte_pkg::TBL_DEPTH];
  logic [7:0] live_syms[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  huffman_table_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  hte_code_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Stall the result side: a requested long hold-off first, else at the phase rate
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("huffman_table_encoder_tb: done, errors");
      $finish;
    end
  end

  // Offer one request beat, idling first at the phase rate; return once accepted
  task automatic send_beat(input hte_pkg::req_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= beat;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (beat.req_type != REQ_NONE)
      sent++;
  endtask

  // Hold the request side until every owed result beat has come
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic hte_pkg::req_t noise_beat(logic [1:0] kind);
    hte_pkg::req_t b;
    b.req_type      = kind;
    b.symbol        = 8'($urandom);
    b.code_bits     = $urandom;
    b.code_len      = 6'($urandom);
    b.entry_present = 1'($urandom);
    return b;
  endfunction

  task automatic load_entry(input logic [7:0] sym, input logic [31:0] code,
                            input logic [5:0] len, input logic keep);
    hte_pkg::req_t b;
    int            i;
    b               = noise_beat(hte_pkg::REQ_LOAD);
    b.symbol        = sym;
    b.code_bits     = code;
    b.code_len      = len;
    b.entry_present = keep;
    if (keep && !tb_live[sym])
      live_syms.insert(live_syms.size(), sym);
    if (!keep && tb_live[sym]) begin
      for (i = 0; i < live_syms.size(); i++) begin
        if (live_syms[i] == sym) begin
          live_syms.delete(i);
          break;
        end
      end
    end
    tb_live[sym] = keep;
    send_beat(b);
  endtask

  task automatic encode_sym(input logic [7:0] sym);
    hte_pkg::req_t b;
    b        = noise_beat(hte_pkg::REQ_ENCODE);
    b.symbol = sym;
    send_beat(b);
  endtask

  task automatic flush_stream();
    send_beat(noise_beat(hte_pkg::REQ_FLUSH));
  endtask

  // Mostly short codes, with zero, full-width and over-cap lengths mixed in
  function automatic logic [5:0] pick_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5)  return 6'd0;
    if (roll < 12) return 6'($urandom_range(63, 33));
    if (roll < 20) return 6'd32;
    return 6'($urandom_range(12, 1));
  endfunction

  // One stream: a few table edits, a run of encodes, usually a flush
  task automatic random_stream();
    int n_edits;
    int n_codes;
    int roll;
    n_edits = $urandom_range(6, 1);
    repeat (n_edits) begin
      if ($urandom_range(99) < 10 && live_syms.size() > 0)
        load_entry(live_syms[$urandom_range(live_syms.size() - 1)], $urandom, pick_len(),
                   1'b0);
      else
        load_entry(8'($urandom), $urandom, pick_len(), 1'b1);
    end
    n_codes = $urandom_range(30, 4);
    repeat (n_codes) begin
      roll = $urandom_range(99);
      if (roll < 3)
        encode_sym(8'($urandom));
      else if (roll < 5)
        send_beat(noise_beat(REQ_NONE));
      else if (live_syms.size() > 0)
        encode_sym(live_syms[$urandom_range(live_syms.size() - 1)]);
      else
        encode_sym(8'($urandom));
    end
    if ($urandom_range(9) != 0)
      flush_stream();
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int goal;
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    goal = sent + PHASE_ITEMS;
    while (sent < goal) random_stream();
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: error path on an empty table
    send_beat(noise_beat(REQ_NONE));
    encode_sym(8'h00);
    encode_sym(8'h00);
    flush_stream();

    // Directed: table extremes and packer boundaries
    load_entry(8'hFF, 32'hA5C3_5A3C, 6'd63, 1'b1);
    load_entry(8'h00, 32'hFFFF_FFFF, 6'd32, 1'b1);
    load_entry(8'h01, 32'h0000_0001, 6'd1, 1'b1);
    load_entry(8'h7F, 32'hFFFF_FF55, 6'd7, 1'b1);
    load_entry(8'h80, 32'hFFFF_FFFF, 6'd0, 1'b1);
    load_entry(8'h02, 32'h0000_0000, 6'd32, 1'b1);
    encode_sym(8'hFF);
    encode_sym(8'h80);
    encode_sym(8'h7F);
    encode_sym(8'h00);
    encode_sym(8'h02);
    encode_sym(8'h01);
    flush_stream();
    flush_stream();

    // Directed: removed entry, then encodes dropped until the flush
    load_entry(8'h01, 32'h0, 6'd0, 1'b0);
    encode_sym(8'h7F);
    encode_sym(8'h01);
    encode_sym(8'hFF);
    flush_stream();
    drain();

    run_phase(13, 50);
    run_phase(50, 13);
    run_phase(0, 0);

    // Long result hold-off while codes keep coming, so the request side backs up
    flush_stream();
    load_entry(8'h5A, $urandom, 6'd24, 1'b1);
    hold_tog <= ~hold_tog;
    repeat (40) encode_sym(8'h5A);
    flush_stream();
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("huffman_table_encoder_tb: done, clean");
    else
      $display("huffman_table_encoder_tb: done, errors");
    $finish;
  end

endmodule
